[sv/blc3_pkg.sv]
// blc3_pkg: widths, payload types and fraction compare for the 3d box line clipper
// standalone package, no dependencies

package blc3_pkg;

   localparam int COORD_BITS = 12;
   localparam int AXES       = 3;
   localparam int NUM_REGS   = 2 * AXES;
   localparam int NUM_PTS    = 2 * AXES;
   localparam int CSR_IW     = 3;

   localparam int DW    = COORD_BITS + 1;
   localparam int MW    = COORD_BITS;
   localparam int PW    = DW + MW + 1;
   localparam int NW    = 2 * DW + 1;
   localparam int XW    = NW + 1;
   localparam int DVW   = MW + 1;
   localparam int QW    = COORD_BITS;
   localparam int DIV_BITS = 3;
   localparam int DIV_ST   = (QW + DIV_BITS - 1) / DIV_BITS;

   // register indexes
   localparam int REG_X_MIN = 0;
   localparam int REG_X_MAX = REG_X_MIN + AXES;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DW-1:0]         diff_type;
   typedef logic [MW-1:0]                mag_type;
   typedef logic signed [NW-1:0]         numer_type;
   typedef logic [CSR_IW-1:0]            csr_idx_type;

   typedef struct packed {
      diff_type n;
      mag_type  m;
   } frac_type;

   // a > b for fractions with nonnegative denominators
   function automatic logic frac_gt(frac_type a, frac_type b);
      logic signed [PW-1:0] pa;
      logic signed [PW-1:0] pb;
      pa = PW'(a.n) * PW'($signed({1'b0, b.m}));
      pb = PW'(b.n) * PW'($signed({1'b0, a.m}));
      return pa > pb;
   endfunction

endpackage

[sv/blc3_ifs.sv]
// channel interfaces for the 3d box line clipper: segment, result and register write
// depends on blc3_pkg

interface blc3_req_if;
   logic                valid;
   logic                ready;
   blc3_pkg::coord_type start_x;
   blc3_pkg::coord_type start_y;
   blc3_pkg::coord_type start_z;
   blc3_pkg::coord_type end_x;
   blc3_pkg::coord_type end_y;
   blc3_pkg::coord_type end_z;
   modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   input ready);
   modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                 output ready);
endinterface

interface blc3_rsp_if;
   logic                valid;
   logic                ready;
   logic                visible;
   blc3_pkg::coord_type clip_start_x;
   blc3_pkg::coord_type clip_start_y;
   blc3_pkg::coord_type clip_start_z;
   blc3_pkg::coord_type clip_end_x;
   blc3_pkg::coord_type clip_end_y;
   blc3_pkg::coord_type clip_end_z;
   modport source (output valid, visible, clip_start_x, clip_start_y, clip_start_z,
                   clip_end_x, clip_end_y, clip_end_z, input ready);
   modport sink (input valid, visible, clip_start_x, clip_start_y, clip_start_z,
                 clip_end_x, clip_end_y, clip_end_z, output ready);
endinterface

interface blc3_csr_if;
   logic                  valid;
   logic                  ready;
   blc3_pkg::csr_idx_type index;
   blc3_pkg::coord_type   data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[sv/box_line_clipper_3d_top.sv]
// box_line_clipper_3d_top: pipelined cyrus-beck clipper of 3d segments against a box
// depends on blc3_pkg and the interfaces in blc3_ifs
//
// usage:
//   req_ch carries one segment per beat (start and end point), rsp_ch returns one
//   beat per segment: visible and the clipped start and end points (zero when not
//   visible). csr_ch writes the six box bounds, index 0..5 = x/y/z min then x/y/z max;
//   higher indexes are dropped. csr_ch is always ready; write only while idle.
// throughput: one segment per cycle while rsp_ch is ready; every stage, the divider stages with
//   3 quotient bits each included, takes a new segment in every cycle that it is not held.
// stages: axis setup, three parametric folds (one axis each), visibility and point
//   numerators, divider setup, four restoring divider stages, output register.
// reset: synchronous, clears all valid bits and loads the full-range box.
// stall: each stage holds while the next one is full and cannot move on, so bubbles close up and
//   req_ch keeps accepting until the pipeline is full behind a stalled rsp_ch.

module box_line_clipper_3d_top (
   input logic       clock,
   input logic       reset,
   blc3_req_if.sink  req_ch,
   blc3_rsp_if.source rsp_ch,
   blc3_csr_if.sink  csr_ch
);
   import blc3_pkg::*;

   localparam int NST    = 7 + DIV_ST;
   localparam int ROW0   = 5;
   localparam int OUTST  = NST - 1;

   typedef struct packed {
      coord_type [AXES-1:0] s;
      diff_type  [AXES-1:0] d;
      frac_type  [AXES-1:0] en_c;
      frac_type  [AXES-1:0] lv_c;
      frac_type             en;
      frac_type             lv;
      logic                 rej;
   } fold_type;

   typedef struct packed {
      numer_type [NUM_PTS-1:0] num;
      mag_type   [NUM_PTS-1:0] den;
      logic                    vis;
   } numer_st_type;

   typedef struct packed {
      logic [XW-1:0]  r;
      logic [DVW-1:0] dv;
      logic [QW-1:0]  q;
      logic           neg;
   } row_type;

   typedef struct packed {
      row_type [NUM_PTS-1:0] row;
      logic                  vis;
   } div_st_type;

   typedef struct packed {
      logic                    visible;
      coord_type [NUM_PTS-1:0] pt;
   } out_type;

   coord_type [NUM_REGS-1:0] box_ff;
   logic [NST-1:0]           vld_ff;
   logic [NST-1:0]           go;
   fold_type                 fold_ff [AXES+1];
   fold_type                 fold_in [AXES+1];
   numer_st_type             numer_ff;
   numer_st_type             numer_in;
   div_st_type               div_ff [DIV_ST+1];
   div_st_type               div_in [DIV_ST+1];
   out_type                  out_ff;
   out_type                  out_in;

   // register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            box_ff[REG_X_MIN + a] <= {1'b1, {(COORD_BITS-1){1'b0}}};
            box_ff[REG_X_MAX + a] <= {1'b0, {(COORD_BITS-1){1'b1}}};
         end
      end else if (csr_ch.valid && csr_ch.ready && csr_ch.index < CSR_IW'(NUM_REGS)) begin
         box_ff[csr_ch.index] <= csr_ch.data;
      end
   end

   // stage flow
   always_comb begin
      go[NST-1] = !vld_ff[NST-1] || rsp_ch.ready;
      for (int k = NST - 2; k >= 0; k--) begin
         go[k] = !vld_ff[k] || go[k+1];
      end
   end

   assign req_ch.ready = go[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (go[0]) begin
            vld_ff[0] <= req_ch.valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (go[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // axis setup
   always_comb begin
      coord_type [AXES-1:0] st;
      coord_type [AXES-1:0] en;
      coord_type lo;
      coord_type hi;
      diff_type  dd;
      st = {req_ch.start_z, req_ch.start_y, req_ch.start_x};
      en = {req_ch.end_z, req_ch.end_y, req_ch.end_x};
      fold_in[0]     = '0;
      fold_in[0].en  = '{n: '0, m: MW'(1)};
      fold_in[0].lv  = '{n: DW'(1), m: MW'(1)};
      fold_in[0].rej = 1'b0;
      for (int a = 0; a < AXES; a++) begin
         lo = box_ff[REG_X_MIN + a];
         hi = box_ff[REG_X_MAX + a];
         dd = DW'(en[a]) - DW'(st[a]);
         fold_in[0].s[a] = st[a];
         fold_in[0].d[a] = dd;
         if (dd > 0) begin
            fold_in[0].en_c[a] = '{n: DW'(lo) - DW'(st[a]), m: dd[MW-1:0]};
            fold_in[0].lv_c[a] = '{n: DW'(hi) - DW'(st[a]), m: dd[MW-1:0]};
         end else if (dd < 0) begin
            fold_in[0].en_c[a] = '{n: DW'(st[a]) - DW'(hi), m: MW'(-dd)};
            fold_in[0].lv_c[a] = '{n: DW'(st[a]) - DW'(lo), m: MW'(-dd)};
         end else begin
            fold_in[0].en_c[a] = '{n: '0, m: MW'(1)};
            fold_in[0].lv_c[a] = '{n: DW'(1), m: MW'(1)};
            if (st[a] < lo || st[a] > hi) begin
               fold_in[0].rej = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go[0]) begin
         fold_ff[0] <= fold_in[0];
      end
   end

   // one axis folded per stage
   for (genvar k = 1; k <= AXES; k++) begin : g_fold
      always_comb begin
         fold_in[k] = fold_ff[k-1];
         if (frac_gt(fold_ff[k-1].en_c[k-1], fold_ff[k-1].en)) begin
            fold_in[k].en = fold_ff[k-1].en_c[k-1];
         end
         if (frac_gt(fold_ff[k-1].lv, fold_ff[k-1].lv_c[k-1])) begin
            fold_in[k].lv = fold_ff[k-1].lv_c[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (go[k]) begin
            fold_ff[k] <= fold_in[k];
         end
      end
   end

   // visibility and point numerators
   always_comb begin
      fold_type f;
      f = fold_ff[AXES];
      numer_in.vis = !f.rej && !frac_gt(f.en, f.lv);
      for (int a = 0; a < AXES; a++) begin
         numer_in.num[a] = NW'(f.s[a]) * NW'($signed({1'b0, f.en.m}))
                         + NW'(f.d[a]) * NW'(f.en.n);
         numer_in.den[a] = f.en.m;
         numer_in.num[a + AXES] = NW'(f.s[a]) * NW'($signed({1'b0, f.lv.m}))
                                + NW'(f.d[a]) * NW'(f.lv.n);
         numer_in.den[a + AXES] = f.lv.m;
      end
   end

   always_ff @(posedge clock) begin
      if (go[AXES+1]) begin
         numer_ff <= numer_in;
      end
   end

   // divider setup: round(n/m) = floor((2|n| + m) / 2m)
   always_comb begin
      logic [NW-1:0] mag;
      div_in[0].vis = numer_ff.vis;
      for (int p = 0; p < NUM_PTS; p++) begin
         mag = numer_ff.num[p] < 0 ? NW'(-numer_ff.num[p]) : NW'(numer_ff.num[p]);
         div_in[0].row[p].neg = numer_ff.num[p] < 0;
         div_in[0].row[p].r   = {mag, 1'b0} + XW'(numer_ff.den[p]);
         div_in[0].row[p].dv  = {numer_ff.den[p], 1'b0};
         div_in[0].row[p].q   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (go[ROW0]) begin
         div_ff[0] <= div_in[0];
      end
   end

   // restoring divider, DIV_BITS quotient bits per stage
   for (genvar j = 0; j < DIV_ST; j++) begin : g_div
      always_comb begin
         logic [XW-1:0] sh;
         int            bi;
         div_in[j+1] = div_ff[j];
         for (int p = 0; p < NUM_PTS; p++) begin
            for (int b = 0; b < DIV_BITS; b++) begin
               bi = QW - 1 - j * DIV_BITS - b;
               if (bi >= 0) begin
                  sh = XW'(div_ff[j].row[p].dv) << bi;
                  if (div_in[j+1].row[p].r >= sh) begin
                     div_in[j+1].row[p].r = div_in[j+1].row[p].r - sh;
                     div_in[j+1].row[p].q[bi] = 1'b1;
                  end
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (go[ROW0 + 1 + j]) begin
            div_ff[j+1] <= div_in[j+1];
         end
      end
   end

   // sign and output register
   always_comb begin
      out_in.visible = div_ff[DIV_ST].vis;
      for (int p = 0; p < NUM_PTS; p++) begin
         if (!div_ff[DIV_ST].vis) begin
            out_in.pt[p] = '0;
         end else if (div_ff[DIV_ST].row[p].neg) begin
            out_in.pt[p] = -$signed(div_ff[DIV_ST].row[p].q);
         end else begin
            out_in.pt[p] = $signed(div_ff[DIV_ST].row[p].q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go[OUTST]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid        = vld_ff[OUTST];
   assign rsp_ch.visible      = out_ff.visible;
   assign rsp_ch.clip_start_x = out_ff.pt[0];
   assign rsp_ch.clip_start_y = out_ff.pt[1];
   assign rsp_ch.clip_start_z = out_ff.pt[2];
   assign rsp_ch.clip_end_x   = out_ff.pt[AXES];
   assign rsp_ch.clip_end_y   = out_ff.pt[AXES+1];
   assign rsp_ch.clip_end_z   = out_ff.pt[AXES+2];

`ifndef NO_ASSERTIONS
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.visible |-> out_ff.pt == '0)
      else $error("hidden segment with nonzero points");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid && vld_ff == '0)
      else $error("pipeline not empty after reset");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> vld_ff == '1)
      else $error("input stalled with a bubble in the pipeline");

   a_fold_order: assert property (@(posedge clock) disable iff (reset)
      vld_ff[AXES] && go[AXES+1] |=>
         numer_ff.vis == $past(!fold_ff[AXES].rej
                               && !frac_gt(fold_ff[AXES].en, fold_ff[AXES].lv)))
      else $error("visible flag disagrees with the folded parameters");
`endif

endmodule
